// ----- rtl/bcsm_pkg.sv -----
package bcsm_pkg;

  localparam int VoltW    = 16;
  localparam int TimeoutW = 32;
  localparam int TickW    = 10;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [TickW-1:0] TickReset = 10'd10;

  typedef enum logic [1:0] {
    CS_OK   = 2'd0,
    CS_LOW  = 2'd1,
    CS_CRIT = 2'd2
  } charge_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LOW_THR  = 8'd0,
    REG_CRIT_THR = 8'd1,
    REG_TIMEOUT  = 8'd2,
    REG_TICK     = 8'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [VoltW-1:0]    low_thr;
    logic [VoltW-1:0]    crit_thr;
    logic [TimeoutW-1:0] timeout;
    logic [TickW-1:0]    tick;
  } cfg_t;

  typedef struct packed {
    logic          result_valid;
    charge_state_e charge_state;
    logic          battery_low;
    logic          battery_critical;
  } result_t;

endpackage

// ----- rtl/bcsm_in_if.sv -----
interface bcsm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] bus_voltage_mv;
  logic        sample_ok;

  modport source (output valid, output bus_voltage_mv, output sample_ok, input ready);
  modport sink (input valid, input bus_voltage_mv, input sample_ok, output ready);
endinterface

// ----- rtl/bcsm_out_if.sv -----
interface bcsm_out_if;
  logic       valid;
  logic       ready;
  logic       result_valid;
  logic [1:0] charge_state;
  logic       battery_low;
  logic       battery_critical;

  modport source (output valid, output result_valid, output charge_state,
                  output battery_low, output battery_critical, input ready);
  modport sink (input valid, input result_valid, input charge_state,
                input battery_low, input battery_critical, output ready);
endinterface

// ----- rtl/bcsm_cfg_if.sv -----
interface bcsm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/battery_charge_state_monitor.sv -----
// Battery undervoltage monitor: one word per sample tick enters on in_i and one result word
// leaves on out_o for every word taken, in order. The block takes a word every cycle unless
// the output stalls; an accepted word is first held in the input register, and its result
// is then presented from the result register, where it waits until it is taken. The input
// side stalls only while both registers are full and the result is
// not being taken. Configuration writes are always ready and take effect on the next cycle;
// they are meant to be made while no word is in flight.
module battery_charge_state_monitor #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bcsm_in_if.sink    in_i,
  bcsm_out_if.source out_o,
  bcsm_cfg_if.sink   cfg_i
);
  import bcsm_pkg::*;

  cfg_t                 cfg_q;
  logic                 in_valid_q;
  logic [VoltW-1:0]     in_volt_q;
  logic                 in_ok_q;
  logic                 out_valid_q;
  result_t              res_q;
  result_t              res_d;
  logic                 advance;
  logic                 step;

  assign advance     = !out_valid_q || out_o.ready;
  assign step        = in_valid_q && advance;
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_thr  <= '0;
      cfg_q.crit_thr <= '0;
      cfg_q.timeout  <= '0;
      cfg_q.tick     <= TickReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_LOW_THR:  cfg_q.low_thr  <= cfg_i.data[VoltW-1:0];
        REG_CRIT_THR: cfg_q.crit_thr <= cfg_i.data[VoltW-1:0];
        REG_TIMEOUT:  cfg_q.timeout  <= cfg_i.data[TimeoutW-1:0];
        REG_TICK:     cfg_q.tick     <= cfg_i.data[TickW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_volt_q <= in_i.bus_voltage_mv;
      in_ok_q   <= in_i.sample_ok;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  bcsm_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .upd_i            (step),
    .bus_voltage_mv_i (in_volt_q),
    .sample_ok_i      (in_ok_q),
    .cfg_i            (cfg_q),
    .result_o         (res_d)
  );

  assign out_o.valid            = out_valid_q;
  assign out_o.result_valid     = res_q.result_valid;
  assign out_o.charge_state     = res_q.charge_state;
  assign out_o.battery_low      = res_q.battery_low;
  assign out_o.battery_critical = res_q.battery_critical;

endmodule

// ----- rtl/bcsm_core.sv -----
module bcsm_core #(
  parameter int COUNTER_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            upd_i,
  input  logic [bcsm_pkg::VoltW-1:0]      bus_voltage_mv_i,
  input  logic                            sample_ok_i,
  input  bcsm_pkg::cfg_t                  cfg_i,
  output bcsm_pkg::result_t               result_o
);
  import bcsm_pkg::*;

  localparam int CmpW = (COUNTER_WIDTH > TimeoutW) ? COUNTER_WIDTH : TimeoutW;

  charge_state_e            state_q, state_d;
  logic [COUNTER_WIDTH-1:0] low_q, low_d;
  logic [COUNTER_WIDTH-1:0] crit_q, crit_d;

  logic                     below_low;
  logic                     below_crit;
  logic [COUNTER_WIDTH-1:0] active_cnt;
  logic [COUNTER_WIDTH:0]   sum;
  logic [COUNTER_WIDTH-1:0] sat_cnt;
  logic                     reached;

  assign below_low  = bus_voltage_mv_i < cfg_i.low_thr;
  assign below_crit = bus_voltage_mv_i < cfg_i.crit_thr;
  assign active_cnt = below_crit ? crit_q : low_q;
  assign sum        = {1'b0, active_cnt} + (COUNTER_WIDTH + 1)'(cfg_i.tick);
  assign sat_cnt    = sum[COUNTER_WIDTH] ? '1 : sum[COUNTER_WIDTH-1:0];
  assign reached    = (cfg_i.timeout != '0) &&
                      (CmpW'(sat_cnt) >= CmpW'(cfg_i.timeout));

  always_comb begin
    state_d = state_q;
    low_d   = low_q;
    crit_d  = crit_q;
    if (upd_i && sample_ok_i) begin
      if (!below_low) begin
        state_d = CS_OK;
        low_d   = '0;
        crit_d  = '0;
      end else if (!below_crit) begin
        low_d  = sat_cnt;
        crit_d = '0;
        if (reached) begin
          state_d = CS_LOW;
        end
      end else begin
        crit_d = sat_cnt;
        low_d  = '0;
        if (reached) begin
          state_d = CS_CRIT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_OK;
      low_q   <= '0;
      crit_q  <= '0;
    end else begin
      state_q <= state_d;
      low_q   <= low_d;
      crit_q  <= crit_d;
    end
  end

  always_comb begin
    result_o.result_valid     = sample_ok_i;
    result_o.charge_state     = state_d;
    result_o.battery_low      = (state_d == CS_LOW) || (state_d == CS_CRIT);
    result_o.battery_critical = (state_d == CS_CRIT);
  end

  a_bad_sample_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && !sample_ok_i |=> $stable(state_q) && $stable(low_q) && $stable(crit_q))
    else $error("state changed on a failed read");

  a_one_counter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((low_q != '0) && (crit_q != '0)))
    else $error("both persistence counters are running");

  a_zero_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && (cfg_i.timeout == '0) |=> (state_q == CS_OK) || $stable(state_q))
    else $error("state left ok with the timeout disabled");

  a_low_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    upd_i && sample_ok_i && below_low && !below_crit && (state_d == CS_LOW)
      && (state_q != CS_LOW) |-> reached)
    else $error("low state entered before the timeout");

endmodule
